@@ sv/xcfr_pkg.sv @@
// Shared constants and types of the XOR checked frame receiver.
`default_nettype none
package xcfr_pkg;

  localparam int unsigned STORE_BYTES    = 64;
  localparam int unsigned MIN_BODY_BYTES = 3;
  localparam int unsigned MAX_BODY_BYTES = 32;
  localparam int unsigned FRAME_OVERHEAD = 3;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADDR_W   = $clog2(STORE_BYTES);
  localparam int unsigned CNT_W    = $clog2(STORE_BYTES + 1);
  localparam int unsigned DLEN_W   = 5;
  localparam int unsigned STATUS_W = 3;

  // Data bytes start after the command type and length bytes.
  localparam int unsigned DATA_OFFSET = 2;

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'hFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_LONG  = 3'd2,
    ST_LEN   = 3'd3,
    ST_XOR   = 3'd4
  } status_e;

endpackage
`default_nettype wire

@@ sv/xcfr_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module xcfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/xor_checked_frame_receiver.sv @@
// Top level of the XOR checked frame receiver: collector, checks and data readout.
//
//   Channel  Dir  Fields (tdata low bit first)
//   s_axis   in   tdata: rx_byte[7:0]
//   m_axis   out  tdata: status[2:0], command_type[10:3], data_len[15:11],
//                        data_byte[23:16], data_index[28:24]; tlast: last
//
// An ordinary byte is written into the body RAM.
// A terminator is checked in its accept cycle; an error or an empty frame
// gives its result in the next cycle. A frame with data is read back from the
// RAM one data byte at a time (read issue, then output load), and the input
// stays stalled for the whole readout of the frame.
// A stalled output holds its result and stalls the readout; a terminator is
// only taken when the output register is free or being emptied.
// Reset clears the byte count, the running XOR and the output valid; the RAM
// needs no clearing since only entries written in the current frame are read.
`default_nettype none
module xor_checked_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[2:0], command_type[10:3], data_len[15:11], data_byte[23:16],
  // data_index[28:24], zero[31:29]
  output logic      [31:0] m_axis_tdata,
  output logic             m_axis_tlast    // last
);

  import xcfr_pkg::*;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_READ,
    S_WAIT
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [BYTE_W-1:0]     xor_q;
  logic [BYTE_W-1:0]     cmd_q;
  logic [BYTE_W-1:0]     len_q;
  logic [DLEN_W-1:0]     dlen_q;
  logic [DLEN_W-1:0]     rd_idx_q;

  logic                  out_valid_q;
  logic                  out_valid_d;
  status_e               out_status_q;
  logic [BYTE_W-1:0]     out_cmd_q;
  logic [DLEN_W-1:0]     out_dlen_q;
  logic [BYTE_W-1:0]     out_data_q;
  logic [DLEN_W-1:0]     out_idx_q;
  logic                  out_last_q;

  logic                  in_fire;
  logic                  is_term;
  logic                  out_free;
  logic [CNT_W-1:0]      cnt_inc;
  status_e               term_status;
  logic [DLEN_W-1:0]     term_dlen;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [BYTE_W-1:0]     ram_rdata;
  logic                  rd_last;

  always_comb begin
    out_free      = !out_valid_q || m_axis_tready;
    s_axis_tready = (state_q == S_COLLECT) && out_free;
    in_fire       = s_axis_tvalid && s_axis_tready;
    is_term       = (s_axis_tdata == TERMINATOR);
    cnt_inc       = cnt_q + CNT_W'(1);
    term_dlen     = DLEN_W'(cnt_q - CNT_W'(FRAME_OVERHEAD));

    // Checks in priority order: size, length byte, then checksum.
    if (cnt_q < CNT_W'(MIN_BODY_BYTES)) begin
      term_status = ST_SHORT;
    end else if (cnt_q > CNT_W'(MAX_BODY_BYTES)) begin
      term_status = ST_LONG;
    end else if ((9'(len_q) + 9'(FRAME_OVERHEAD)) != 9'(cnt_q)) begin
      term_status = ST_LEN;
    end else if (xor_q != '0) begin
      term_status = ST_XOR;
    end else begin
      term_status = ST_OK;
    end

    ram_we    = in_fire && !is_term;
    ram_re    = (state_q == S_READ);
    ram_raddr = ADDR_W'(rd_idx_q) + ADDR_W'(DATA_OFFSET);
    rd_last   = ((rd_idx_q + DLEN_W'(1)) == dlen_q);

    // The output register is loaded by a single-result terminator or by a
    // readout step; otherwise it empties once its transfer completes.
    out_valid_d = out_valid_q && !m_axis_tready;
    if ((in_fire && is_term && ((term_status != ST_OK) || (term_dlen == '0))) ||
        ((state_q == S_WAIT) && out_free)) begin
      out_valid_d = 1'b1;
    end
  end

  xcfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_body_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[ADDR_W-1:0]),
    .wdata_i(s_axis_tdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_COLLECT;
      cnt_q        <= '0;
      xor_q        <= '0;
      cmd_q        <= '0;
      len_q        <= '0;
      dlen_q       <= '0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_cmd_q    <= '0;
      out_dlen_q   <= '0;
      out_data_q   <= '0;
      out_idx_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_COLLECT: begin
          if (in_fire && !is_term) begin
            if (cnt_q == CNT_W'(0)) begin
              cmd_q <= s_axis_tdata;
            end
            if (cnt_q == CNT_W'(1)) begin
              len_q <= s_axis_tdata;
            end
            // A full store without a terminator is dropped.
            if (cnt_inc == CNT_W'(STORE_BYTES)) begin
              cnt_q <= '0;
              xor_q <= '0;
            end else begin
              cnt_q <= cnt_inc;
              xor_q <= xor_q ^ s_axis_tdata;
            end
          end else if (in_fire) begin
            cnt_q <= '0;
            xor_q <= '0;
            if (term_status != ST_OK) begin
              out_status_q <= term_status;
              out_cmd_q    <= '0;
              out_dlen_q   <= '0;
              out_data_q   <= '0;
              out_idx_q    <= '0;
              out_last_q   <= 1'b1;
            end else if (term_dlen == '0) begin
              out_status_q <= ST_OK;
              out_cmd_q    <= cmd_q;
              out_dlen_q   <= '0;
              out_data_q   <= '0;
              out_idx_q    <= '0;
              out_last_q   <= 1'b1;
            end else begin
              dlen_q   <= term_dlen;
              rd_idx_q <= '0;
              state_q  <= S_READ;
            end
          end
        end
        S_READ: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            out_status_q <= ST_OK;
            out_cmd_q    <= cmd_q;
            out_dlen_q   <= dlen_q;
            out_data_q   <= ram_rdata;
            out_idx_q    <= rd_idx_q;
            out_last_q   <= rd_last;
            if (rd_last) begin
              state_q <= S_COLLECT;
            end else begin
              rd_idx_q <= rd_idx_q + DLEN_W'(1);
              state_q  <= S_READ;
            end
          end
        end
        default: begin
          state_q <= S_COLLECT;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_idx_q, out_data_q, out_dlen_q, out_cmd_q,
                          out_status_q};

  // The input is closed for the whole readout of a frame.
  a_no_input_in_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COLLECT) |-> !s_axis_tready)
    else $error("input accepted during data readout");

  // The count wraps before it can reach the store size.
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(STORE_BYTES))
    else $error("byte count out of range");

  // An error result is always the only, and so the last, result of a frame.
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q != ST_OK)) |-> m_axis_tlast)
    else $error("error result without last");

  // Readout never addresses beyond the announced data.
  a_rd_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_READ) || (state_q == S_WAIT)) |-> (rd_idx_q < dlen_q))
    else $error("readout index beyond frame data");

  // Every accepted terminator starts a fresh body.
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_term) |=> ((cnt_q == '0) && (xor_q == '0)))
    else $error("terminator did not clear the collector");

endmodule
`default_nettype wire

@@ test/xcfr_stream_checker.sv @@
// Result predictor and comparator for the XOR checked frame receiver streams.
module xcfr_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // rx_byte[7:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], command_type[10:3], data_len[15:11], data_byte[23:16],
  // data_index[28:24], zero[31:29]
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,    // last
  output int          fail_count_o,
  output int          results_due_o
);

  import xcfr_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   command_type;
    logic [DLEN_W-1:0]   data_len;
    logic [BYTE_W-1:0]   data_byte;
    logic [DLEN_W-1:0]   data_index;
    logic                last;
  } frame_result_t;

  logic [BYTE_W-1:0] body_mem [STORE_BYTES];
  logic [CNT_W-1:0]  body_cnt;
  logic [BYTE_W-1:0] body_xor;
  frame_result_t     awaited_results [$];
  int                fails;

  function automatic string show(frame_result_t r);
    return $sformatf("status %0d cmd %02h len %0d byte %02h idx %0d last %0b",
                     r.status, r.command_type, r.data_len, r.data_byte,
                     r.data_index, r.last);
  endfunction

  // Folds one accepted byte into the frame body; a terminator turns the body
  // into the results that the block has to deliver.
  task automatic collect_rx_byte(input logic [BYTE_W-1:0] rx);
    status_e       st;
    int unsigned   n;
    int unsigned   n_data;
    frame_result_t r;
    if (rx != TERMINATOR) begin
      if (body_cnt < STORE_BYTES) begin
        body_mem[body_cnt[ADDR_W-1:0]] = rx;
        body_xor = body_xor ^ rx;
        body_cnt = body_cnt + 1'b1;
      end
      // A store that fills up without a terminator is dropped.
      if (body_cnt >= STORE_BYTES) begin
        body_cnt = '0;
        body_xor = '0;
      end
    end else begin
      n = body_cnt;
      if (n < MIN_BODY_BYTES) begin
        st = ST_SHORT;
      end else if (n > MAX_BODY_BYTES) begin
        st = ST_LONG;
      end else if (body_mem[1] + FRAME_OVERHEAD != n) begin
        st = ST_LEN;
      end else if (body_xor != '0) begin
        st = ST_XOR;
      end else begin
        st = ST_OK;
      end
      body_cnt = '0;
      body_xor = '0;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      if (st != ST_OK) begin
        awaited_results.push_back(r);
      end else begin
        n_data = n - FRAME_OVERHEAD;
        r.command_type = body_mem[0];
        if (n_data == 0) begin
          awaited_results.push_back(r);
        end else begin
          for (int unsigned i = 0; i < n_data; i++) begin
            r.data_len   = n_data[DLEN_W-1:0];
            r.data_byte  = body_mem[(i + DATA_OFFSET) % STORE_BYTES];
            r.data_index = i[DLEN_W-1:0];
            r.last       = (i + 1 == n_data);
            awaited_results.push_back(r);
          end
        end
      end
    end
  endtask

  task automatic match_output_transfer();
    frame_result_t got;
    frame_result_t want;
    got.status       = status_e'(m_axis_tdata[2:0]);
    got.command_type = m_axis_tdata[10:3];
    got.data_len     = m_axis_tdata[15:11];
    got.data_byte    = m_axis_tdata[23:16];
    got.data_index   = m_axis_tdata[28:24];
    got.last         = m_axis_tlast;
    if (awaited_results.size() == 0) begin
      if (fails < 10) begin
        $display("unexpected result transfer: %s", show(got));
      end
      fails++;
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.command_type !== want.command_type ||
          got.data_len !== want.data_len || got.data_byte !== want.data_byte ||
          got.data_index !== want.data_index || got.last !== want.last ||
          m_axis_tdata[31:29] !== 3'b000) begin
        if (fails < 10) begin
          $display("result mismatch: expected %s, got %s (pad %0b)",
                   show(want), show(got), m_axis_tdata[31:29]);
        end
        fails++;
      end
    end
  endtask

  // Outputs are compared before the byte of the same edge is folded in: a
  // result can never leave in the cycle its terminator is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      body_cnt = '0;
      body_xor = '0;
      fails = 0;
      awaited_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        match_output_transfer();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        collect_rx_byte(s_axis_tdata);
      end
    end
    fail_count_o  <= fails;
    results_due_o <= awaited_results.size();
  end

endmodule

@@ test/xor_checked_frame_receiver_test.sv @@
// Testbench top for the XOR checked frame receiver: byte stimulus, output stalls, verdict.
module xor_checked_frame_receiver_test;
  import xcfr_pkg::*;

  typedef enum int {FRAME_GOOD, FRAME_BAD_XOR, FRAME_BAD_LEN} frame_flaw_e;
  typedef logic [BYTE_W-1:0] byte_q_t [$];

  localparam int unsigned RX_BYTES_WANTED  = 410;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned HOLD_FRAME       = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  int          fail_count;
  int          results_due;
  int unsigned bytes_sent = 0;
  int unsigned rx_hold_cycles = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  always #1 clk_i = ~clk_i;

  xor_checked_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  xcfr_stream_checker u_frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  function automatic byte_q_t random_payload(input int unsigned n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 254)));
    return q;
  endfunction

  // Offers one byte, after a random gap unless tx_calm is set, and returns once the transfer is done.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input byte_q_t data,
                            input frame_flaw_e flaw);
    logic [BYTE_W-1:0] len_b;
    logic [BYTE_W-1:0] rest;
    logic [BYTE_W-1:0] flip;
    len_b = 8'(data.size());
    if (flaw == FRAME_BAD_LEN) begin
      len_b = 8'((data.size() + $urandom_range(1, 254)) % 255);
    end
    rest = len_b;
    foreach (data[i]) rest = rest ^ data[i];
    flip = (flaw == FRAME_BAD_XOR) ? 8'($urandom_range(1, 255)) : 8'h00;
    // The checksum byte must not look like a terminator.
    while ((rest ^ cmd ^ flip) == TERMINATOR || cmd == TERMINATOR) begin
      cmd = 8'($urandom_range(0, 254));
    end
    send_byte(cmd);
    send_byte(len_b);
    foreach (data[i]) send_byte(data[i]);
    send_byte(rest ^ cmd ^ flip);
    send_byte(TERMINATOR);
  endtask

  initial begin : tx_side
    byte_q_t     payload;
    int unsigned frame_no;
    int unsigned pick;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty body, two-byte body, frame without data, extreme bytes, then the
    // length and checksum errors.
    send_byte(TERMINATOR);
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(TERMINATOR);
    payload = {};
    send_frame(8'h00, payload, FRAME_GOOD);
    payload = '{8'h00, 8'hFE};
    send_frame(8'hFE, payload, FRAME_GOOD);
    payload = '{8'h5A};
    send_frame(8'h21, payload, FRAME_BAD_LEN);
    send_frame(8'h80, payload, FRAME_BAD_XOR);

    frame_no = 0;
    while (bytes_sent < RX_BYTES_WANTED) begin
      frame_no++;
      tx_calm = (frame_no % 10) >= 7;
      rx_calm = (frame_no % 13) >= 9;
      if (frame_no == HOLD_FRAME) begin
        rx_hold_cycles = LONG_HOLD_CYCLES;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        payload = random_payload((pick < 6) ? $urandom_range(20, 29) : $urandom_range(0, 6));
        send_frame(8'($urandom_range(0, 254)), payload, FRAME_GOOD);
      end else if (pick < 65) begin
        payload = random_payload($urandom_range(0, 29));
        send_frame(8'($urandom_range(0, 254)), payload, FRAME_BAD_XOR);
      end else if (pick < 73) begin
        payload = random_payload($urandom_range(0, 29));
        send_frame(8'($urandom_range(0, 254)), payload, FRAME_BAD_LEN);
      end else if (pick < 78) begin
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 254)));
        send_byte(TERMINATOR);
      end else if (pick < 83) begin
        repeat ($urandom_range(33, 63)) send_byte(8'($urandom_range(0, 254)));
        send_byte(TERMINATOR);
      end else if (pick < 87) begin
        // The store overflows and is dropped; the next frame must get through.
        repeat (STORE_BYTES) send_byte(8'($urandom_range(0, 254)));
        payload = random_payload($urandom_range(0, 6));
        send_frame(8'($urandom_range(0, 254)), payload, FRAME_GOOD);
      end else begin
        repeat ($urandom_range(4, 16)) send_byte(8'($urandom_range(0, 255)));
        send_byte(TERMINATOR);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("xor_checked_frame_receiver verification clean");
    end else begin
      $display("xor_checked_frame_receiver verification failed");
    end
    $finish;
  end

  initial begin : rx_side
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = rx_calm ? 0 : $urandom_range(0, 8);
      // A requested long hold-off replaces the ordinary stall once.
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    #400000;
    $display("xor_checked_frame_receiver verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/xcfr_pkg.sv
sv/xcfr_ram.sv
sv/xor_checked_frame_receiver.sv
test/xcfr_stream_checker.sv
test/xor_checked_frame_receiver_test.sv
